// File: rtl/core/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 RGB box blur.
`timescale 1ns / 1ps

package bb3_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
    // The input row runs up to two rows past the frame while results drain.
    localparam int INROW_W = $clog2(MAX_HEIGHT + 3);

    // Configuration register fields.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int WCMP_W     = (WID_W > IMG_W_W) ? WID_W : IMG_W_W;
    localparam int HCMP_W     = (HGT_W > IMG_H_W) ? HGT_W : IMG_H_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(480);

    // Pixel and arithmetic widths.
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = NUM_CH * CH_W;
    localparam int ROWSUM_W = 10;
    localparam int SUM_W    = 12;
    localparam int NUM_W    = 13;
    localparam int CNT_W    = 4;
    localparam int RECIP_W  = 20;
    localparam int RECIP_SH = 20;
    localparam int PROD_W   = NUM_W + RECIP_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             rd_en;
        logic             pix_ld;
        logic             pix_zero;
        logic             shift;
        logic             clr_win;
        logic             sum1;
        logic             sum2;
        logic             div;
        logic             load_out;
        logic             frame_end;
        logic             col_lo;
        logic             col_hi;
        logic             row_lo;
        logic             row_hi;
        logic [COL_W-1:0] addr;
    } bb3_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } bb3_stat_t;

    // Channel idx of a packed pixel: 0 is red, 1 green, 2 blue.
    function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] pix, input int idx);
        return pix[PIX_W-1-idx*CH_W -: CH_W];
    endfunction

    // Reciprocal of 2*count scaled by 2^RECIP_SH and rounded up. The product with
    // any numerator below 2^NUM_W then gives the exact quotient after the shift.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            CNT_W'(1): m = RECIP_W'(524288);
            CNT_W'(2): m = RECIP_W'(262144);
            CNT_W'(3): m = RECIP_W'(174763);
            CNT_W'(4): m = RECIP_W'(131072);
            CNT_W'(6): m = RECIP_W'(87382);
            CNT_W'(9): m = RECIP_W'(58255);
            default:   m = RECIP_W'(524288);
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/bb3_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bb3_ctrl.sv
// Controller of the box blur: sequencing state machine, positions and configuration.
`timescale 1ns / 1ps

module bb3_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    output bb3_pkg::bb3_cmd_t              cmd_o,
    input  bb3_pkg::bb3_stat_t             stat_i
);

    import bb3_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SUM1  = 3'd3;
    localparam logic [2:0] S_SUM2  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]         state_reg,   state_next;
    logic [IMG_W_W-1:0] img_w_reg,   img_w_next;
    logic [IMG_H_W-1:0] img_h_reg,   img_h_next;
    logic [COL_W-1:0]   in_col_reg,  in_col_next;
    logic [INROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic               emit_reg,    emit_next;

    logic [WCMP_W-1:0]  w_ext;
    logic [HCMP_W-1:0]  h_ext;
    logic [WID_W-1:0]   eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic               frame_done;
    logic               pos_ready;
    logic               col_last;
    logic               col_lo, col_hi, row_lo, row_hi;
    logic               cfg_wr;

    // Effective frame size, clamped to the supported range.
    always_comb begin
        w_ext = WCMP_W'(img_w_reg);
        h_ext = HCMP_W'(img_h_reg);
        if (w_ext == '0) begin
            eff_w = WID_W'(1);
        end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(w_ext);
        end
        if (h_ext == '0) begin
            eff_h = HGT_W'(1);
        end else if (h_ext > HCMP_W'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(h_ext);
        end
    end

    assign frame_done = in_row_reg >= INROW_W'(eff_h);
    // A result is due once the input is one row and one pixel ahead of it.
    assign pos_ready  = (in_row_reg >= INROW_W'(2)) ||
                        ((in_row_reg == INROW_W'(1)) && (in_col_reg != '0));
    assign col_last   = (WID_W'(in_col_reg) + WID_W'(1)) >= eff_w;

    // Which neighbours of the next result lie inside the frame.
    assign col_lo = out_col_reg != '0;
    assign col_hi = (WID_W'(out_col_reg) + WID_W'(1)) < eff_w;
    assign row_lo = out_row_reg != '0;
    assign row_hi = (HGT_W'(out_row_reg) + HGT_W'(1)) < eff_h;

    assign cfg_ready = 1'b1;

    always_comb begin
        state_next   = state_reg;
        img_w_next   = img_w_reg;
        img_h_next   = img_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        emit_next    = emit_reg;
        cfg_wr       = 1'b0;

        cmd_o        = '0;
        cmd_o.addr   = in_col_reg;
        cmd_o.col_lo = col_lo;
        cmd_o.col_hi = col_hi;
        cmd_o.row_lo = row_lo;
        cmd_o.row_hi = row_hi;

        s_ready = (state_reg == S_IDLE);

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    img_w_next = cfg_data[IMG_W_W-1:0];
                    cfg_wr     = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    img_h_next = cfg_data[IMG_H_W-1:0];
                    cfg_wr     = 1'b1;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                // A drain before the frame is complete is dropped here.
                if (s_valid && (frame_done || !s_cmd)) begin
                    cmd_o.rd_en    = 1'b1;
                    cmd_o.pix_ld   = 1'b1;
                    cmd_o.pix_zero = frame_done;
                    emit_next      = pos_ready;
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                cmd_o.shift = 1'b1;
                if (col_last) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + INROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                state_next = emit_reg ? S_SUM1 : S_IDLE;
            end
            S_SUM1: begin
                cmd_o.sum1 = 1'b1;
                state_next = S_SUM2;
            end
            S_SUM2: begin
                cmd_o.sum2 = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd_o.div  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!stat_i.out_full) begin
                    cmd_o.load_out  = 1'b1;
                    cmd_o.frame_end = !row_hi && !col_hi;
                    if (!row_hi && !col_hi) begin
                        // Last result of the frame: start over.
                        cmd_o.clr_win = 1'b1;
                        in_col_next   = '0;
                        in_row_next   = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                    end else if (!col_hi) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A register write restarts the frame; the line stores keep their data.
        if (cfg_wr) begin
            cmd_o.clr_win = 1'b1;
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            img_w_reg   <= IMG_W_RESET;
            img_h_reg   <= IMG_H_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            emit_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            img_w_reg   <= img_w_next;
            img_h_reg   <= img_h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            emit_reg    <= emit_next;
        end
    end

endmodule

// File: rtl/core/bb3_dp.sv
// Datapath of the box blur: line stores, 3x3 window, sums, rounding divide, output register.
`timescale 1ns / 1ps

module bb3_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bb3_pkg::bb3_cmd_t         cmd_i,
    output bb3_pkg::bb3_stat_t        stat_o,
    input  logic [bb3_pkg::CH_W-1:0]  s_red_in,
    input  logic [bb3_pkg::CH_W-1:0]  s_green_in,
    input  logic [bb3_pkg::CH_W-1:0]  s_blue_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bb3_pkg::CH_W-1:0]  m_red_out,
    output logic [bb3_pkg::CH_W-1:0]  m_green_out,
    output logic [bb3_pkg::CH_W-1:0]  m_blue_out,
    output logic                      m_frame_end
);

    import bb3_pkg::*;

    logic [PIX_W-1:0]    pix_reg;
    logic [PIX_W-1:0]    up_rd;
    logic [PIX_W-1:0]    mid_rd;
    logic [PIX_W-1:0]    win_reg [3][3];
    logic [ROWSUM_W-1:0] rowsum_reg [3][NUM_CH];
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]    num_reg [NUM_CH];
    logic [CH_W-1:0]     q_reg [NUM_CH];
    logic [PROD_W-1:0]   prod [NUM_CH];
    logic [SUM_W-1:0]    total [NUM_CH];
    logic [1:0]          ncols, nrows;
    logic                m_valid_reg;
    logic [CH_W-1:0]     red_reg, green_reg, blue_reg;
    logic                frame_end_reg;

    // Row two above and row one above the incoming column.
    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (aclk),
        .we    (cmd_i.shift),
        .re    (cmd_i.rd_en),
        .addr  (cmd_i.addr),
        .wdata (mid_rd),
        .rdata (up_rd)
    );

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk   (aclk),
        .we    (cmd_i.shift),
        .re    (cmd_i.rd_en),
        .addr  (cmd_i.addr),
        .wdata (pix_reg),
        .rdata (mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (cmd_i.pix_ld) begin
            pix_reg <= cmd_i.pix_zero ? '0 : {s_red_in, s_green_in, s_blue_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd_i.clr_win) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (cmd_i.shift) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= up_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= pix_reg;
        end
    end

    assign ncols = 2'd1 + {1'b0, cmd_i.col_lo} + {1'b0, cmd_i.col_hi};
    assign nrows = 2'd1 + {1'b0, cmd_i.row_lo} + {1'b0, cmd_i.row_hi};

    // First step: masked sum across each window row, and the neighbour count.
    always_ff @(posedge aclk) begin
        if (cmd_i.sum1) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    rowsum_reg[k][c] <=
                        (cmd_i.col_lo ? ROWSUM_W'(chan(win_reg[k][0], c)) : '0) +
                        ROWSUM_W'(chan(win_reg[k][1], c)) +
                        (cmd_i.col_hi ? ROWSUM_W'(chan(win_reg[k][2], c)) : '0);
                end
            end
            cnt_reg <= CNT_W'(ncols) * CNT_W'(nrows);
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            total[c] = (cmd_i.row_lo ? SUM_W'(rowsum_reg[0][c]) : '0) +
                       SUM_W'(rowsum_reg[1][c]) +
                       (cmd_i.row_hi ? SUM_W'(rowsum_reg[2][c]) : '0);
            prod[c]  = PROD_W'(num_reg[c]) * PROD_W'(recip(cnt_reg));
        end
    end

    // Second step: numerator 2*sum + count for round half up.
    always_ff @(posedge aclk) begin
        if (cmd_i.sum2) begin
            for (int c = 0; c < NUM_CH; c++) begin
                num_reg[c] <= {total[c], 1'b0} + NUM_W'(cnt_reg);
            end
        end
    end

    // Third step: divide by 2*count through the scaled reciprocal.
    always_ff @(posedge aclk) begin
        if (cmd_i.div) begin
            for (int c = 0; c < NUM_CH; c++) begin
                q_reg[c] <= prod[c][RECIP_SH +: CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            red_reg       <= q_reg[0];
            green_reg     <= q_reg[1];
            blue_reg      <= q_reg[2];
            frame_end_reg <= cmd_i.frame_end;
        end
    end

    assign stat_o.out_full = m_valid_reg && !m_ready;

    assign m_valid     = m_valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// File: rtl/core/box_blur_3x3_rgb_top.sv
// Top level of the streaming 3x3 RGB box blur.
`timescale 1ns / 1ps

// Streaming 3x3 box blur over one RGB frame in raster order.
// Input channel (s_): one transfer per item. s_cmd = 0 carries a pixel, s_cmd = 1
// drains one pending result. Results trail the input by one row plus one pixel, so
// after the last pixel of a frame width + 1 drain items push out the rest; a drain
// sent before the frame is complete is dropped, a pixel sent after it acts as a drain.
// Output channel (m_): rounded per-channel mean of the in-frame neighbours, with
// m_frame_end set on the last result of the frame; the frame then starts over.
// Configuration channel (cfg_): index 0 is image_width, index 1 image_height; a write
// restarts the frame and is meant for an idle block. cfg_ready is always high.
// Sequence: an item that yields a result is held by the controller through the line store
// read, window update, row sums, total, divide and output load, and the output load waits
// while the output register is full; an item without result passes only the read and the
// window update, and a dropped drain is taken in the idle state. The single-port line
// store read and the three arithmetic steps make up this sequence.
// A stalled receiver holds the result in the output register; the block still takes
// the next item and waits only when a new result is ready to load.
// Reset (aresetn, synchronous, active low) restores 640 x 480 and the start of a
// frame; the line stores are not cleared and need no clearing pass.
module box_blur_3x3_rgb_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [bb3_pkg::CH_W-1:0]       s_red_in,
    input  logic [bb3_pkg::CH_W-1:0]       s_green_in,
    input  logic [bb3_pkg::CH_W-1:0]       s_blue_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bb3_pkg::CH_W-1:0]       m_red_out,
    output logic [bb3_pkg::CH_W-1:0]       m_green_out,
    output logic [bb3_pkg::CH_W-1:0]       m_blue_out,
    output logic                           m_frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bb3_pkg::*;

    bb3_cmd_t  cmd;
    bb3_stat_t stat;

    bb3_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_o     (cmd),
        .stat_i    (stat)
    );

    bb3_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (cmd),
        .stat_o      (stat),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_frame_end (m_frame_end)
    );

endmodule

// File: rtl/core/bb3_checker.sv
// Port-level assertions for the box blur top level, attached by bind.
`timescale 1ns / 1ps

module bb3_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_cmd,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red_out,
    input logic [7:0] m_green_out,
    input logic [7:0] m_blue_out,
    input logic       m_frame_end
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out) &&
                                $stable(m_blue_out) && $stable(m_frame_end))
        else $error("result changed while stalled");

    // A new result is loaded only after the arithmetic steps, never while idle.
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready) && !$past(s_ready, 2))
        else $error("result appeared without the compute sequence");

    // A pixel transfer always goes through the line store read.
    a_pixel_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_cmd |=> !s_ready)
        else $error("pixel transfer did not occupy the block");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_cmd       (s_cmd),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red_out   (m_red_out),
    .m_green_out (m_green_out),
    .m_blue_out  (m_blue_out),
    .m_frame_end (m_frame_end)
);
